// ===== rtl/core/nst_pkg.sv =====
// Shared types, codes and default sizes for the named semaphore table.
`default_nettype none
package nst_pkg;

    localparam int NUM_SEMS_DEF    = 16;
    localparam int NAME_BITS_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int PID_BITS_DEF    = 16;

    localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] COUNT_MIN = 16'sh8000;
    localparam logic [15:0]        USERS_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_OPEN  = 2'd0,
        ACT_CLOSE = 2'd1,
        ACT_POST  = 2'd2,
        ACT_WAIT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_QUEUE_FULL = 2'd3
    } status_t;

    typedef struct packed {
        action_t     action;
        logic [63:0] name_key;
        logic [14:0] initial_value;
        logic [15:0] caller_pid;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [3:0]         slot;
        logic               must_block;
        logic               woken_valid;
        logic [15:0]        woken_pid;
        logic signed [15:0] count_after;
    } rsp_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic capture;
        logic scan;
        logic fetch;
        logic peek;
        logic exec;
    } cmd_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/nst_ctrl.sv =====
// Sequencer for the named semaphore table: search, fetch, peek and execute steps.
`default_nettype none
module nst_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire nst_pkg::stat_t stat,
    output nst_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_FETCH,
        S_PEEK,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        state_next  = state_reg;
        ready_next  = ready_reg;
        cmd         = '0;
        cmd.capture = req_valid && ready_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && ready_reg)
                begin
                    state_next = S_SEARCH;
                    ready_next = 1'b0;
                end
            end
            S_SEARCH:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_PEEK;
            end
            S_PEEK:
            begin
                cmd.peek   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign req_ready = ready_reg;

endmodule
`default_nettype wire

// ===== rtl/core/nst_dp.sv =====
// Datapath of the named semaphore table: slot stores, wait queues and result register.
`default_nettype none
module nst_dp #(
    parameter int NUM_SEMS    = nst_pkg::NUM_SEMS_DEF,
    parameter int NAME_BITS   = nst_pkg::NAME_BITS_DEF,
    parameter int QUEUE_DEPTH = nst_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = nst_pkg::PID_BITS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire nst_pkg::req_t req,
    input  wire nst_pkg::cmd_t cmd,
    output nst_pkg::stat_t     stat,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output nst_pkg::rsp_t      rsp
);

    localparam int SW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int WN  = NUM_SEMS * QUEUE_DEPTH;
    localparam int AW  = (WN > 1) ? $clog2(WN) : 1;
    localparam int PW  = (PID_BITS < 16) ? PID_BITS : 16;
    localparam logic [SW-1:0] LAST_IDX  = SW'(NUM_SEMS - 1);
    localparam logic [QW-1:0] LAST_HEAD = QW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] DEPTH_F   = FW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] DEPTH_A   = AW'(QUEUE_DEPTH);

    // Stores; only the used flags (used_reg) need a reset value.
    logic [NAME_BITS-1:0] slot_name  [NUM_SEMS];
    logic signed [15:0]   slot_count [NUM_SEMS];
    logic [15:0]          slot_users [NUM_SEMS];
    logic [QW-1:0]        q_head     [NUM_SEMS];
    logic [FW-1:0]        q_fill     [NUM_SEMS];
    logic [PW-1:0]        waiter_ids [WN];
    logic [NUM_SEMS-1:0]  used_reg;

    // Captured request.
    nst_pkg::action_t     act_reg;
    logic [NAME_BITS-1:0] key_reg;
    logic [14:0]          init_reg;
    logic [PW-1:0]        pid_reg;

    // Search pipeline.
    logic [SW-1:0]        scan_idx_reg;
    logic                 rd_v_reg;
    logic [SW-1:0]        rd_idx_reg;
    logic [NAME_BITS-1:0] name_q_reg;
    logic                 used_q_reg;
    logic                 match_reg;
    logic [SW-1:0]        match_idx_reg;
    logic                 free_reg;
    logic [SW-1:0]        free_idx_reg;

    // Values read for the addressed slot.
    logic signed [15:0]   cnt_q_reg;
    logic [15:0]          users_q_reg;
    logic [QW-1:0]        head_q_reg;
    logic [FW-1:0]        fill_q_reg;
    logic [PW-1:0]        wid_q_reg;

    logic                 out_valid_reg;
    nst_pkg::rsp_t        out_reg;

    logic [SW-1:0]        sel_idx;
    logic [SW+3:0]        slot_ext;
    logic [AW-1:0]        slot_base;
    logic [FW:0]          tail_sum;
    logic [QW-1:0]        tail_idx;
    logic [QW-1:0]        head_inc;

    nst_pkg::rsp_t        res;
    logic                 we_name;
    logic                 we_count;
    logic                 we_users;
    logic                 we_queue;
    logic                 we_wid;
    logic                 set_used;
    logic                 clr_used;
    logic signed [15:0]   count_new;
    logic [15:0]          users_new;
    logic [QW-1:0]        head_new;
    logic [FW-1:0]        fill_new;

    assign sel_idx   = match_reg ? match_idx_reg : free_idx_reg;
    assign slot_ext  = (SW + 4)'(sel_idx);
    assign slot_base = AW'(sel_idx) * DEPTH_A;
    assign tail_sum  = (FW + 1)'(head_q_reg) + (FW + 1)'(fill_q_reg);
    assign tail_idx  = (tail_sum >= (FW + 1)'(QUEUE_DEPTH))
                       ? QW'(tail_sum - (FW + 1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    assign head_inc  = (head_q_reg == LAST_HEAD) ? '0 : head_q_reg + 1'b1;

    assign stat.scan_last = (scan_idx_reg == LAST_IDX);
    assign stat.out_free  = !out_valid_reg || rsp_ready;

    always_comb
    begin
        res        = '0;
        we_name    = 1'b0;
        we_count   = 1'b0;
        we_users   = 1'b0;
        we_queue   = 1'b0;
        we_wid     = 1'b0;
        set_used   = 1'b0;
        clr_used   = 1'b0;
        count_new  = cnt_q_reg;
        users_new  = users_q_reg;
        head_new   = head_q_reg;
        fill_new   = fill_q_reg;
        if (act_reg == nst_pkg::ACT_OPEN)
        begin
            if (match_reg)
            begin
                if (users_q_reg != nst_pkg::USERS_MAX)
                begin
                    users_new = users_q_reg + 16'd1;
                end
                we_users        = 1'b1;
                res.slot        = slot_ext[3:0];
                res.count_after = cnt_q_reg;
            end
            else if (free_reg)
            begin
                we_name         = 1'b1;
                we_count        = 1'b1;
                we_users        = 1'b1;
                we_queue        = 1'b1;
                set_used        = 1'b1;
                count_new       = 16'(init_reg);
                users_new       = 16'd1;
                head_new        = '0;
                fill_new        = '0;
                res.slot        = slot_ext[3:0];
                res.count_after = 16'(init_reg);
            end
            else
            begin
                res.status = nst_pkg::ST_TABLE_FULL;
            end
        end
        else if (!match_reg)
        begin
            res.status = nst_pkg::ST_NOT_FOUND;
        end
        else
        begin
            res.slot = slot_ext[3:0];
            case (act_reg)
                nst_pkg::ACT_CLOSE:
                begin
                    if (users_q_reg > 16'd1)
                    begin
                        users_new = users_q_reg - 16'd1;
                        we_users  = 1'b1;
                    end
                    else
                    begin
                        clr_used = 1'b1;
                        we_queue = 1'b1;
                        head_new = '0;
                        fill_new = '0;
                    end
                end
                nst_pkg::ACT_POST:
                begin
                    if (fill_q_reg != '0)
                    begin
                        res.woken_valid = 1'b1;
                        res.woken_pid   = 16'(wid_q_reg);
                        head_new        = head_inc;
                        fill_new        = fill_q_reg - 1'b1;
                        we_queue        = 1'b1;
                    end
                    if (cnt_q_reg != nst_pkg::COUNT_MAX)
                    begin
                        count_new = cnt_q_reg + 16'sd1;
                    end
                    we_count = 1'b1;
                end
                nst_pkg::ACT_WAIT:
                begin
                    if (cnt_q_reg < 16'sd1)
                    begin
                        if (fill_q_reg >= DEPTH_F)
                        begin
                            res.status = nst_pkg::ST_QUEUE_FULL;
                        end
                        else
                        begin
                            we_wid         = 1'b1;
                            fill_new       = fill_q_reg + 1'b1;
                            we_queue       = 1'b1;
                            res.must_block = 1'b1;
                            if (cnt_q_reg != nst_pkg::COUNT_MIN)
                            begin
                                count_new = cnt_q_reg - 16'sd1;
                            end
                            we_count = 1'b1;
                        end
                    end
                    else
                    begin
                        count_new = cnt_q_reg - 16'sd1;
                        we_count  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            res.count_after = count_new;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.scan;
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
                if (set_used)
                begin
                    used_reg[sel_idx] <= 1'b1;
                end
                if (clr_used)
                begin
                    used_reg[sel_idx] <= 1'b0;
                end
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, search and slot reads.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg      <= req.action;
            key_reg      <= req.name_key[NAME_BITS-1:0];
            init_reg     <= req.initial_value;
            pid_reg      <= req.caller_pid[PW-1:0];
            scan_idx_reg <= '0;
            match_reg    <= 1'b0;
            free_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.scan)
            begin
                name_q_reg   <= slot_name[scan_idx_reg];
                used_q_reg   <= used_reg[scan_idx_reg];
                rd_idx_reg   <= scan_idx_reg;
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (rd_v_reg)
            begin
                if (used_q_reg && (name_q_reg == key_reg) && !match_reg)
                begin
                    match_reg     <= 1'b1;
                    match_idx_reg <= rd_idx_reg;
                end
                if (!used_q_reg && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
            end
        end
        if (cmd.fetch)
        begin
            cnt_q_reg   <= slot_count[sel_idx];
            users_q_reg <= slot_users[sel_idx];
            head_q_reg  <= q_head[sel_idx];
            fill_q_reg  <= q_fill[sel_idx];
        end
        if (cmd.peek)
        begin
            wid_q_reg <= waiter_ids[slot_base + AW'(head_q_reg)];
        end
        if (cmd.exec)
        begin
            out_reg <= res;
        end
    end

    // Store writes.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (we_name)
            begin
                slot_name[sel_idx] <= key_reg;
            end
            if (we_count)
            begin
                slot_count[sel_idx] <= count_new;
            end
            if (we_users)
            begin
                slot_users[sel_idx] <= users_new;
            end
            if (we_queue)
            begin
                q_head[sel_idx] <= head_new;
                q_fill[sel_idx] <= fill_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && we_wid)
        begin
            waiter_ids[slot_base + AW'(tail_idx)] <= pid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/named_semaphore_table.sv =====
// Top level of the named semaphore table: sequencer and datapath.
//
//  Channel | Signals                          | Carries
//  --------+----------------------------------+--------------------------------------
//  req     | req_valid, req_ready, req        | action, name key, initial count, pid
//  rsp     | rsp_valid, rsp_ready, rsp        | status, slot, block/wake flags, count
//
// Each request runs through a name search, which reads one slot name per cycle
// from the name store, with the compare of the last name in the following cycle,
// followed by a fetch of the slot, a read of the oldest waiter and an execute
// step that writes everything back and registers the response. The input opens
// again with the response.
// Reset clears the slot-used flags and the handshake state; the stores need no
// clearing, since a slot's fields and its queue are written when it is created.
// A stalled response holds in its output register and the execute step waits
// for it to drain; a new request is accepted as soon as the execute step is done.
`default_nettype none
module named_semaphore_table #(
    parameter int NUM_SEMS    = nst_pkg::NUM_SEMS_DEF,
    parameter int NAME_BITS   = nst_pkg::NAME_BITS_DEF,
    parameter int QUEUE_DEPTH = nst_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = nst_pkg::PID_BITS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire nst_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output nst_pkg::rsp_t      rsp
);

    // The sequencer only steers; all state of the table lives in the datapath.
    nst_pkg::cmd_t  cmd;
    nst_pkg::stat_t stat;

    nst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    nst_dp #(
        .NUM_SEMS    (NUM_SEMS),
        .NAME_BITS   (NAME_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// ===== rtl/core/nst_chk.sv =====
// Port checker for the named semaphore table, bound to the top level.
`default_nettype none
module nst_chk
(
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire nst_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in progress");

    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == nst_pkg::ST_NOT_FOUND |->
        rsp.slot == 4'd0 && rsp.count_after == 16'sd0 && !rsp.must_block
        && !rsp.woken_valid && rsp.woken_pid == 16'd0)
        else $error("unknown name response carries data");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.must_block || rsp.woken_valid) |->
        rsp.status == nst_pkg::ST_OK && !(rsp.must_block && rsp.woken_valid))
        else $error("block and wake flags inconsistent");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == nst_pkg::ST_TABLE_FULL |->
        rsp.slot == 4'd0 && rsp.count_after == 16'sd0)
        else $error("table full response carries data");

endmodule

bind named_semaphore_table nst_chk u_nst_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the named semaphore table, with predictor and random requests.
`default_nettype none
module tb;

    localparam int SLOTS  = 16;
    localparam int QDEPTH = 8;
    localparam int LIMIT  = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    nst_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    nst_pkg::rsp_t rsp;

    always #2 clk = ~clk;

    named_semaphore_table uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    // The predictor keeps its own copy of the semaphore table.
    logic               sem_used  [SLOTS];
    logic [63:0]        sem_name  [SLOTS];
    logic signed [15:0] sem_count [SLOTS];
    logic [15:0]        sem_users [SLOTS];
    logic [15:0]        sem_queue [SLOTS][QDEPTH];
    int unsigned        sem_head  [SLOTS];
    int unsigned        sem_fill  [SLOTS];

    nst_pkg::req_t pending_reqs[$];
    nst_pkg::rsp_t expected_rsps[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   requests_sent = 0;
    int   blocks_seen = 0;
    int   wakes_seen = 0;
    bit   stim_done = 1'b0;
    bit   calm = 1'b0;        // no idling in the last part of the run
    bit   hold_req = 1'b0;    // sender pauses until everything has drained
    int   req_gap = 0;
    int   rsp_gap = 0;
    logic [63:0] name_pool[6];

    function automatic nst_pkg::rsp_t predict_semaphore(nst_pkg::req_t r);
        nst_pkg::rsp_t o;
        int s;
        int unsigned t;
        o = '0;
        s = -1;
        for (int i = 0; i < SLOTS; i++)
            if (s < 0 && sem_used[i] && sem_name[i] == r.name_key)
                s = i;
        if (r.action == nst_pkg::ACT_OPEN)
        begin
            if (s >= 0)
            begin
                if (sem_users[s] != nst_pkg::USERS_MAX)
                    sem_users[s]++;
            end
            else
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && !sem_used[i])
                        s = i;
                if (s >= 0)
                begin
                    sem_used[s]  = 1'b1;
                    sem_name[s]  = r.name_key;
                    sem_count[s] = {1'b0, r.initial_value};
                    sem_users[s] = 16'd1;
                    sem_head[s]  = 0;
                    sem_fill[s]  = 0;
                end
                else
                    o.status = nst_pkg::ST_TABLE_FULL;
            end
            if (s >= 0)
            begin
                o.slot = s[3:0];
                o.count_after = sem_count[s];
            end
        end
        else if (s < 0)
            o.status = nst_pkg::ST_NOT_FOUND;
        else
        begin
            o.slot = s[3:0];
            case (r.action)
                nst_pkg::ACT_CLOSE:
                    if (sem_users[s] > 16'd1)
                        sem_users[s]--;
                    else
                    begin
                        sem_used[s] = 1'b0;
                        sem_fill[s] = 0;
                        sem_head[s] = 0;
                    end
                nst_pkg::ACT_POST:
                begin
                    if (sem_fill[s] > 0)
                    begin
                        o.woken_valid = 1'b1;
                        o.woken_pid = sem_queue[s][sem_head[s]];
                        sem_head[s] = (sem_head[s] + 1) % QDEPTH;
                        sem_fill[s]--;
                    end
                    if (sem_count[s] != nst_pkg::COUNT_MAX)
                        sem_count[s]++;
                end
                default:
                    if (sem_count[s] < 16'sd1)
                    begin
                        if (sem_fill[s] >= QDEPTH)
                            o.status = nst_pkg::ST_QUEUE_FULL;
                        else
                        begin
                            t = (sem_head[s] + sem_fill[s]) % QDEPTH;
                            sem_queue[s][t] = r.caller_pid;
                            sem_fill[s]++;
                            o.must_block = 1'b1;
                            if (sem_count[s] != nst_pkg::COUNT_MIN)
                                sem_count[s]--;
                        end
                    end
                    else
                        sem_count[s]--;
            endcase
            o.count_after = sem_count[s];
        end
        return o;
    endfunction

    function automatic nst_pkg::req_t make_req(nst_pkg::action_t a, logic [63:0] k,
                                               logic [14:0] iv, logic [15:0] pid);
        nst_pkg::req_t r;
        r.action = a;
        r.name_key = k;
        r.initial_value = iv;
        r.caller_pid = pid;
        return r;
    endfunction

    function automatic nst_pkg::req_t random_req();
        nst_pkg::action_t a;
        logic [63:0] k;
        a = nst_pkg::action_t'($urandom_range(3));
        if ($urandom_range(9) == 0)
            k = {$urandom, $urandom};
        else
            k = name_pool[$urandom_range(5)];
        // Small initial counts keep the wait queues busy; a few take a random 15-bit value.
        return make_req(a, k,
            ($urandom_range(7) == 0) ? 15'($urandom) : 15'($urandom_range(2)),
            16'($urandom));
    endfunction

    // Driver: presents queued requests, with random idle bursts between them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(predict_semaphore(req));
                requests_sent++;
            end
            if (!req_valid || req_ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap <= req_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !hold_req)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    if (!calm && $urandom_range(5) == 0)
                        req_gap <= $urandom_range(17, 1);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each response against the oldest prediction.
    always @(posedge clk)
    begin
        nst_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: expected no response actual %p", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp !== want)
                    begin
                        $display("%0t: expected %p actual %p", $time, want, rsp);
                        mismatches++;
                    end
                    blocks_seen += rsp.must_block;
                    wakes_seen += rsp.woken_valid;
                end
            end
            if (rsp_gap > 0)
            begin
                rsp_gap <= rsp_gap - 1;
                rsp_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(7) == 0)
            begin
                rsp_gap <= $urandom_range(17, 1) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            sem_used[i] = 1'b0;
        for (int i = 0; i < 6; i++)
            name_pool[i] = {$urandom, $urandom};
        name_pool[0] = '0;
        name_pool[1] = '1;
        // Directed: lookups on an empty table, the top of the count range, queue full,
        // table full, freeing with waiters queued.
        pending_reqs.push_back(make_req(nst_pkg::ACT_POST, 64'd0, 15'd0, 16'd0));
        pending_reqs.push_back(make_req(nst_pkg::ACT_OPEN, 64'd0, 15'h7FFF, 16'hFFFF));
        pending_reqs.push_back(make_req(nst_pkg::ACT_POST, 64'd0, 15'd0, 16'd0));
        pending_reqs.push_back(make_req(nst_pkg::ACT_OPEN, '1, 15'd0, 16'd0));
        for (int i = 0; i < 9; i++)
            pending_reqs.push_back(make_req(nst_pkg::ACT_WAIT, '1, 15'd0,
                                            16'(16'hFFF0 + i)));
        pending_reqs.push_back(make_req(nst_pkg::ACT_POST, '1, 15'd0, 16'd0));
        pending_reqs.push_back(make_req(nst_pkg::ACT_OPEN, '1, 15'd0, 16'd0));
        pending_reqs.push_back(make_req(nst_pkg::ACT_CLOSE, '1, 15'd0, 16'd0));
        pending_reqs.push_back(make_req(nst_pkg::ACT_CLOSE, '1, 15'd0, 16'd0));
        pending_reqs.push_back(make_req(nst_pkg::ACT_WAIT, '1, 15'd0, 16'd0));
        for (int i = 0; i < 16; i++)
            pending_reqs.push_back(make_req(nst_pkg::ACT_OPEN, 64'(i + 100), 15'(i),
                                            16'd0));
        pending_reqs.push_back(make_req(nst_pkg::ACT_CLOSE, 64'd0, 15'd0, 16'd0));
        pending_reqs.push_back(make_req(nst_pkg::ACT_CLOSE, 64'd100, 15'd0, 16'd0));
        for (int i = 1; i < 16; i++)
            pending_reqs.push_back(make_req(nst_pkg::ACT_CLOSE, 64'(i + 100), 15'd0,
                                            16'd0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Drain the directed part before the random part begins.
        hold_req = 1'b1;
        @(posedge clk);
        hold_req = 1'b0;
        wait (pending_reqs.size() == 0 && !req_valid);
        hold_req = 1'b1;
        wait (expected_rsps.size() == 0);
        hold_req = 1'b0;

        for (int i = 0; i < 1500; i++)
        begin
            pending_reqs.push_back(random_req());
            if (i == 1300)
            begin
                wait (pending_reqs.size() == 0 && !req_valid);
                calm = 1'b1;
            end
        end
        wait (pending_reqs.size() == 0 && !req_valid);
        wait (expected_rsps.size() == 0);
        repeat (60) @(posedge clk);
        stim_done = 1'b1;
        $display("Ran %0d requests over a small name pool: %0d waits blocked, %0d waiters woken.",
                 requests_sent, blocks_seen, wakes_seen);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/nst_pkg.sv
rtl/core/nst_ctrl.sv
rtl/core/nst_dp.sv
rtl/core/named_semaphore_table.sv
rtl/core/nst_chk.sv
dv/tb.sv
